// ===== rtl/core/lcmn_pkg.sv =====
// Shared types, constants and saturation helpers for the live cepstral
// mean normalizer. No dependencies; every other file imports this package.
`default_nettype none

package lcmn_pkg;

  localparam int MAX_COEFS = 32;
  localparam int IDX_W     = $clog2(MAX_COEFS);
  localparam int LEN_W     = 6;
  localparam int COEF_W    = 16;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 16;
  localparam int WIDE_W    = SUM_W + 2;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_NO_FRAMES = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [4:0]               coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic                     frame_last;
  } lcmn_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] norm_value;
    logic                     status;
  } lcmn_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } lcmn_state_t;

  typedef struct packed {
    logic sample;
    logic reject;
    logic upd_begin;
    logic div_start;
    logic mean_write;
    logic finish;
  } lcmn_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic idx_done;
    logic div_done;
    logic out_free;
  } lcmn_stat_t;

  // Saturate a wide signed value to the coefficient width.
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [WIDE_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    if ((&v[WIDE_W-1:COEF_W-1]) || !(|v[WIDE_W-1:COEF_W-1])) begin
      r = v[COEF_W-1:0];
    end else begin
      r = v[WIDE_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a wide signed value to the running sum width.
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [WIDE_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if ((&v[WIDE_W-1:SUM_W-1]) || !(|v[WIDE_W-1:SUM_W-1])) begin
      r = v[SUM_W-1:0];
    end else begin
      r = v[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/live_cepstral_mean_normalizer.sv =====
// Top level of the live cepstral mean normalizer: joins the controller and
// the datapath. Depends on lcmn_pkg, lcmn_ctrl and lcmn_dp.
//
//   channel   direction  handshake            payload
//   in        into block in_valid / in_stall  in_data  (lcmn_in_t)
//   out       out of     out_valid / out_stall out_data (lcmn_out_t)
//   cfg       into block cfg_write            cfg_data (vector length)
//
// Samples stream at one per cycle while the output register drains. An
// update request walks indices 1 to length-1 (length capped at 32) through
// the bit-serial divider and holds in_stall high meanwhile. An update with
// no counted frames is rejected with the no-frames status. Reset is
// synchronous and clears the mean and sum stores and the frame counter; a
// response waits in the output register while out_stall is high.
`default_nettype none

module live_cepstral_mean_normalizer
  import lcmn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  lcmn_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lcmn_out_t        out_data
);

  lcmn_cmd_t  cmd;
  lcmn_stat_t stat;

  lcmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (in_data.action),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lcmn_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lcmn_div.sv =====
// Bit-serial restoring divider: signed sum over unsigned frame count,
// quotient truncated toward zero. Depends on lcmn_pkg.
`default_nettype none

module lcmn_div
  import lcmn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  mag;
  logic              neg;

  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] diff;
  logic           qbit;

  // The shifted remainder stays below twice the divisor, so the top bit of the
  // difference is the borrow.
  assign rem_sh   = {rem, mag[SUM_W-1]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign qbit     = !diff[CNT_W];
  assign quotient = mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CW'(DIV_STEPS)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The magnitude register shifts the quotient in; the last cycle restores the sign.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      mag <= dividend[SUM_W-1] ? -dividend : dividend;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      if (cnt == DIV_CW'(DIV_STEPS)) begin
        mag <= neg ? -mag : mag;
      end else begin
        rem <= qbit ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        mag <= {mag[SUM_W-2:0], qbit};
        cnt <= cnt + DIV_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcmn_ctrl.sv =====
// Controller state machine: accepts requests and sequences the mean update.
// Depends on lcmn_pkg.
`default_nettype none

module lcmn_ctrl
  import lcmn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       action,
  input  lcmn_stat_t stat,
  output logic       in_stall,
  output lcmn_cmd_t  cmd
);

  lcmn_state_t state;
  lcmn_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          if (action == ACT_SAMPLE) begin
            cmd.sample = 1'b1;
          end else if (stat.count_zero) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.upd_begin = 1'b1;
            state_next    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.idx_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.mean_write = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // The update's response waits here until the output register is free.
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lcmn_dp.sv =====
// Datapath: length register, mean and sum stores, frame counter, update
// arithmetic with the serial divider, and the output register. Depends on
// lcmn_pkg and lcmn_div.
`default_nettype none

module lcmn_dp
  import lcmn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [LEN_W-1:0] cfg_data,
  input  lcmn_in_t         in_data,
  input  lcmn_cmd_t        cmd,
  output lcmn_stat_t       stat,
  output logic             out_valid,
  input  logic             out_stall,
  output lcmn_out_t        out_data
);

  logic [LEN_W-1:0]         vector_length;
  logic signed [COEF_W-1:0] mean_mem [MAX_COEFS];
  logic signed [SUM_W-1:0]  sum_mem [MAX_COEFS];
  logic [CNT_W-1:0]         frame_count;
  logic [LEN_W-1:0]         upd_idx;

  logic [LEN_W-1:0]         len_eff;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         upd_addr;
  logic signed [COEF_W-1:0] mean_rd;
  logic signed [SUM_W-1:0]  sum_rd;
  logic                     in_range;
  logic signed [SUM_W-1:0]  sum_new;
  logic signed [COEF_W-1:0] res;
  logic signed [WIDE_W-1:0] mean_acc;
  logic signed [COEF_W-1:0] mean_new;
  logic                     div_done;
  logic signed [SUM_W-1:0]  quot;
  logic                     out_free;
  logic                     out_load;
  lcmn_out_t                out_next;

  assign len_eff  = (vector_length > LEN_W'(MAX_COEFS)) ? LEN_W'(MAX_COEFS) : vector_length;
  assign upd_addr = upd_idx[IDX_W-1:0];
  assign rd_addr  = cmd.sample ? in_data.coef_index[IDX_W-1:0] : upd_addr;
  assign mean_rd  = mean_mem[rd_addr];
  assign sum_rd   = sum_mem[rd_addr];

  assign in_range = (in_data.coef_index != '0) &&
                    ({1'b0, in_data.coef_index} < len_eff);

  assign sum_new = sat_sum({{(WIDE_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd} +
                           {{(WIDE_W-COEF_W){in_data.coef_value[COEF_W-1]}},
                            in_data.coef_value});

  always_comb begin
    res = in_data.coef_value;
    if (in_range) begin
      res = sat_coef({{(WIDE_W-COEF_W){in_data.coef_value[COEF_W-1]}}, in_data.coef_value} -
                     {{(WIDE_W-COEF_W){mean_rd[COEF_W-1]}}, mean_rd});
    end
  end

  // New mean is the floor of half of (old mean + quotient).
  assign mean_acc = {{(WIDE_W-COEF_W){mean_rd[COEF_W-1]}}, mean_rd} +
                    {{(WIDE_W-SUM_W){quot[SUM_W-1]}}, quot};
  assign mean_new = sat_coef(mean_acc >>> 1);

  lcmn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_rd),
    .divisor  (frame_count),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_W'(13);
      frame_count   <= '0;
      upd_idx       <= '0;
      for (int i = 0; i < MAX_COEFS; i++) begin
        mean_mem[i] <= '0;
        sum_mem[i]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        vector_length <= cfg_data;
      end
      if (cmd.sample && in_data.frame_last && !(&frame_count)) begin
        frame_count <= frame_count + CNT_W'(1);
      end else if (cmd.finish) begin
        frame_count <= '0;
      end
      if (cmd.upd_begin) begin
        upd_idx <= LEN_W'(1);
      end else if (cmd.mean_write) begin
        upd_idx <= upd_idx + LEN_W'(1);
      end
      if (cmd.sample && in_range) begin
        sum_mem[rd_addr] <= sum_new;
      end
      if (cmd.mean_write) begin
        mean_mem[upd_addr] <= mean_new;
        sum_mem[upd_addr]  <= '0;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign out_load = cmd.sample || cmd.reject || cmd.finish;

  always_comb begin
    out_next.norm_value = '0;
    out_next.status     = STATUS_DONE;
    if (cmd.sample) begin
      out_next.norm_value = res;
    end else if (cmd.reject) begin
      out_next.status = STATUS_NO_FRAMES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  assign stat.count_zero = (frame_count == '0);
  assign stat.idx_done   = (upd_idx >= len_eff);
  assign stat.div_done   = div_done;
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

// ===== verif/live_cepstral_mean_normalizer_tb.sv =====
// Self-checking testbench for live_cepstral_mean_normalizer: a directed table, then random
// utterances across several vector lengths, then a run of full-scale frames on two indices.
// Depends on lcmn_pkg and the RTL of the block; responses are checked in order.
`default_nettype none

module live_cepstral_mean_normalizer_tb;
  import lcmn_pkg::*;

  localparam int  RANDOM_ITEMS   = 1300;
  localparam int  SAT_FRAMES     = 40;
  localparam int  SETTLE_CYCLES  = 40;
  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  MAX_REPORTS    = 10;
  localparam longint COEF_HI = (longint'(1) << (COEF_W - 1)) - 1;
  localparam longint COEF_LO = -(longint'(1) << (COEF_W - 1));
  localparam longint SUM_HI  = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO  = -(longint'(1) << (SUM_W - 1));

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    lcmn_in_t  req;
    bit        typed;
    lcmn_out_t want;
  } stim_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  lcmn_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lcmn_out_t        out_data;

  // Predictor state, kept in step with the block at every accepted request.
  logic [LEN_W-1:0]         model_len;
  logic signed [COEF_W-1:0] mean_q [MAX_COEFS];
  logic signed [SUM_W-1:0]  sum_q  [MAX_COEFS];
  logic [CNT_W-1:0]         frames_seen;

  lcmn_out_t   norm_due_q[$];
  stim_row_t   directed_plan[$];
  int          fail_count   = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;
  int          quiet_cycles = 0;
  bit          rush         = 1'b0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          mode_left    = 0;
  int          stall_tick   = 0;

  always #5 clk = ~clk;

  live_cepstral_mean_normalizer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic lcmn_out_t normalize_step(input lcmn_in_t req);
    lcmn_out_t rsp;
    int        span;
    int        idx;
    longint    x;
    longint    quot;
    rsp.norm_value = '0;
    rsp.status     = STATUS_DONE;
    span = (model_len > MAX_COEFS) ? MAX_COEFS : int'(model_len);
    idx  = int'(req.coef_index);
    x    = longint'($signed(req.coef_value));
    if (req.action == ACT_SAMPLE) begin
      rsp.norm_value = req.coef_value;
      if (idx >= 1 && idx < span) begin
        sum_q[idx]     = SUM_W'(clip(longint'(sum_q[idx]) + x, SUM_LO, SUM_HI));
        rsp.norm_value = COEF_W'(clip(x - longint'(mean_q[idx]), COEF_LO, COEF_HI));
      end
      if (req.frame_last && frames_seen != '1) frames_seen++;
    end else if (frames_seen == '0) begin
      rsp.status = STATUS_NO_FRAMES;
    end else begin
      for (int i = 1; i < span; i++) begin
        // Division truncates toward zero; the halving then rounds toward minus infinity.
        quot      = longint'(sum_q[i]) / longint'(frames_seen);
        mean_q[i] = COEF_W'(clip((longint'(mean_q[i]) + quot) >>> 1, COEF_LO, COEF_HI));
        sum_q[i]  = '0;
      end
      frames_seen = '0;
    end
    return rsp;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'(int'($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  task automatic send_request(input lcmn_in_t req, input bit typed, input lcmn_out_t typed_rsp);
    lcmn_out_t predicted;
    int        gap;
    if (burst_left == 0) begin
      gap = 0;
      if (!rush) gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      // Valid is only lowered when a real gap follows, so it never drops and rises in one step.
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = normalize_step(req);
    norm_due_q.push_back(typed ? typed_rsp : predicted);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_sample(input logic [4:0] idx, input logic [COEF_W-1:0] val,
                             input logic last);
    lcmn_in_t req;
    req.action     = ACT_SAMPLE;
    req.coef_index = idx;
    req.coef_value = val;
    req.frame_last = last;
    send_request(req, 1'b0, '0);
  endtask

  task automatic send_update();
    lcmn_in_t req;
    req            = $bits(lcmn_in_t)'($urandom);
    req.action     = ACT_UPDATE;
    send_request(req, 1'b0, '0);
  endtask

  task automatic plan_row(input logic act, input logic [4:0] idx, input logic [COEF_W-1:0] val,
                          input logic last, input bit typed, input logic [COEF_W-1:0] norm,
                          input logic st);
    stim_row_t entry;
    entry.req.action      = act;
    entry.req.coef_index  = idx;
    entry.req.coef_value  = val;
    entry.req.frame_last  = last;
    entry.typed           = typed;
    entry.want.norm_value = norm;
    entry.want.status     = st;
    directed_plan.push_back(entry);
  endtask

  // Well-formed speech: whole frames (length capped at 32; 1 to 4 if below 2), then an update.
  task automatic send_utterance();
    int frames;
    int width;
    frames = $urandom_range(1, 10);
    width  = (model_len > MAX_COEFS) ? MAX_COEFS : int'(model_len);
    if (width < 2) width = $urandom_range(1, 4);
    repeat (frames) begin
      for (int i = 0; i < width; i++) send_sample(5'(i), rand_coef(), i == width - 1);
    end
    send_update();
  endtask

  task automatic send_noise();
    lcmn_in_t req;
    repeat ($urandom_range(1, 5)) begin
      req            = $bits(lcmn_in_t)'($urandom);
      req.action     = ($urandom_range(0, 7) == 0) ? ACT_UPDATE : ACT_SAMPLE;
      req.coef_value = rand_coef();
      send_request(req, 1'b0, '0);
    end
  endtask

  task automatic drain_and_settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (norm_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    model_len = len;
  endtask

  always @(posedge clk) begin : receiver_pattern
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    stall_tick++;
    if (rush) begin
      out_stall <= ($urandom_range(0, 7) == 0);
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_responses
    lcmn_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (norm_due_q.size() == 0) begin
        flag_mismatch($sformatf("response with none expected: norm_value %0d status %0b",
                                $signed(out_data.norm_value), out_data.status));
      end else begin
        want = norm_due_q.pop_front();
        if (out_data.norm_value !== want.norm_value)
          flag_mismatch($sformatf("norm_value expected %0d got %0d",
                                  $signed(want.norm_value), $signed(out_data.norm_value)));
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status expected %0b got %0b", want.status, out_data.status));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("live_cepstral_mean_normalizer_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int len_plan[$] = '{2, 32, 0, 1, 63, 33, 13, 13};
    int quota;
    foreach (mean_q[i]) begin
      mean_q[i] = '0;
      sum_q[i]  = '0;
    end
    model_len   = 13;
    frames_seen = '0;
    len_plan[6] = $urandom_range(3, 31);

    // Vector length is 13 out of reset for the whole table.
    plan_row(ACT_UPDATE, 0,  16'h0000, 1, 1, 16'h0000, STATUS_NO_FRAMES);
    plan_row(ACT_SAMPLE, 0,  16'h7FFF, 0, 1, 16'h7FFF, STATUS_DONE);
    plan_row(ACT_SAMPLE, 0,  16'h8000, 0, 1, 16'h8000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 1,  16'h7FFF, 0, 1, 16'h7FFF, STATUS_DONE);
    plan_row(ACT_SAMPLE, 12, 16'h8000, 0, 1, 16'h8000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 13, 16'h1234, 0, 1, 16'h1234, STATUS_DONE);
    plan_row(ACT_SAMPLE, 31, 16'hFFFF, 1, 1, 16'hFFFF, STATUS_DONE);
    plan_row(ACT_UPDATE, 5,  16'hABCD, 0, 1, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 1,  16'h8000, 0, 1, 16'h8000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 12, 16'h7FFF, 0, 1, 16'h7FFF, STATUS_DONE);
    plan_row(ACT_SAMPLE, 1,  16'h0100, 0, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 2,  16'hFF00, 1, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 5,  16'h0280, 1, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_UPDATE, 0,  16'h0000, 1, 1, 16'h0000, STATUS_DONE);
    plan_row(ACT_UPDATE, 0,  16'h0000, 0, 1, 16'h0000, STATUS_NO_FRAMES);
    plan_row(ACT_SAMPLE, 1,  16'h0000, 0, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 2,  16'h0000, 0, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 12, 16'h0000, 1, 0, 16'h0000, STATUS_DONE);
    plan_row(ACT_SAMPLE, 30, 16'h5555, 0, 1, 16'h5555, STATUS_DONE);
    plan_row(ACT_UPDATE, 31, 16'hFFFF, 1, 1, 16'h0000, STATUS_DONE);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r])
      send_request(directed_plan[r].req, directed_plan[r].typed, directed_plan[r].want);
    drain_and_settle();

    quota = RANDOM_ITEMS / len_plan.size();
    foreach (len_plan[p]) begin
      write_length(LEN_W'(len_plan[p]));
      rush = ($urandom_range(0, 3) == 0);
      quota = items_sent + RANDOM_ITEMS / len_plan.size();
      while (items_sent < quota) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_utterance();
      end
      rush = 1'b0;
      drain_and_settle();
    end

    // Full-scale frames of opposite sign on the two live indices, then updates.
    write_length(3);
    send_sample(0, rand_coef(), 1);
    send_update();
    rush = 1'b1;
    repeat (SAT_FRAMES) begin
      send_sample(1, 16'h7FFF, 0);
      send_sample(2, 16'h8000, 1);
    end
    rush = 1'b0;
    send_update();
    repeat (3) begin
      send_sample(1, rand_coef(), 0);
      send_sample(2, rand_coef(), 1);
    end
    send_update();
    drain_and_settle();

    if (fail_count == 0) begin
      $display("live_cepstral_mean_normalizer_tb: PASS");
    end else begin
      $display("live_cepstral_mean_normalizer_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/lcmn_pkg.sv
rtl/core/lcmn_div.sv
rtl/core/lcmn_ctrl.sv
rtl/core/lcmn_dp.sv
rtl/core/live_cepstral_mean_normalizer.sv
verif/live_cepstral_mean_normalizer_tb.sv
